// ----- design/two_class_priority_queue_assert.svh -----
// Assertion macros used by the queue datapath.
// Each macro checks one implication under the given clock and reset.
`ifndef TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TCPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define TCPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TCPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TCPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/tcpq_pkg.sv -----
`timescale 1ns / 1ps

package tcpq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int TAG_BITS     = 16;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int FIELD_CNT_BITS = 5;
   localparam int CAP_BITS   = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
   localparam int FRAME_BITS = PAYLOAD_BITS + TAG_BITS + 1;

   localparam int MODE_BITS     = 3;
   localparam int REQ_USER_BITS = MODE_BITS + 2;
   localparam int REQ_DATA_RAW  = TAG_BITS + PAYLOAD_BITS;
   localparam int REQ_DATA_BITS = ((REQ_DATA_RAW + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 5;
   localparam int RSP_DATA_RAW  = PAYLOAD_BITS + TAG_BITS + 2 * FIELD_CNT_BITS;
   localparam int RSP_DATA_BITS = ((RSP_DATA_RAW + 7) / 8) * 8;

   localparam logic [MODE_BITS-1:0] MODE_ENQUEUE = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_PEEK    = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_RETIRE  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_CLOSE   = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_FLUSH   = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE  = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_COUNT   = 3'd6;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_CLOSED = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   // How the latched request is carried out.
   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_PEEK,
      KIND_WALK
   } kind_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic walk_read;
      logic walk_step;
      logic peek_done;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     walk_last;
      logic     rsp_free;
   } stat_type;

endpackage

// ----- design/tcpq_ram.sv -----
`timescale 1ns / 1ps

module tcpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/tcpq_ctrl.sv -----
`timescale 1ns / 1ps

module tcpq_ctrl
   import tcpq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PEEK,
      S_WALK_RD,
      S_WALK_CHK
   } state_type;

   state_type state_ff, state_in;

   // sequence one request at a time
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.kind)
               KIND_PEEK: begin
                  cmd.exec = 1'b1;
                  state_in = S_PEEK;
               end
               KIND_WALK: begin
                  cmd.exec = 1'b1;
                  state_in = S_WALK_RD;
               end
               default: begin
                  if (stat.rsp_free) begin
                     cmd.exec = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_PEEK: begin
            if (stat.rsp_free) begin
               cmd.peek_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_WALK_RD: begin
            cmd.walk_read = 1'b1;
            state_in      = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (!stat.walk_last) begin
               cmd.walk_step = 1'b1;
               state_in      = S_WALK_RD;
            end else if (stat.rsp_free) begin
               cmd.walk_step = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ----- design/tcpq_datapath.sv -----
`timescale 1ns / 1ps

`include "two_class_priority_queue_assert.svh"

module tcpq_datapath
   import tcpq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [MODE_BITS-1:0]    req_mode,
   input  logic                    req_is_control,
   input  logic                    req_is_tagged,
   input  logic [TAG_BITS-1:0]     req_generation,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic                    csr_valid,
   input  logic [CAP_BITS-1:0]     csr_data,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic                    rsp_tready,
   output logic                    rsp_valid,
   output status_type              rsp_status,
   output logic [PAYLOAD_BITS-1:0] rsp_head_payload,
   output logic                    rsp_head_is_control,
   output logic                    rsp_head_is_tagged,
   output logic [TAG_BITS-1:0]     rsp_head_generation,
   output logic [FIELD_CNT_BITS-1:0] rsp_item_count,
   output logic [FIELD_CNT_BITS-1:0] rsp_total_queued,
   output logic                    rsp_accepting
);

   // pointer plus offset, wrapped to the store depth
   function automatic logic [PTR_BITS-1:0] wrap_add(input logic [PTR_BITS-1:0] base,
                                                    input logic [CNT_BITS-1:0] off);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS+1)'(base) + (CNT_BITS+1)'(off);
      if (sum >= (CNT_BITS+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_BITS+1)'(QUEUE_DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

   // latched request
   logic [MODE_BITS-1:0]    mode_ff;
   logic                    ctl_ff, tag_ff;
   logic [TAG_BITS-1:0]     gen_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;

   // queue state
   logic [CAP_BITS-1:0] cap_ff;
   logic [CNT_BITS-1:0] ccount_ff, ccount_in, fcount_ff, fcount_in;
   logic [PTR_BITS-1:0] chead_ff, chead_in, fhead_ff, fhead_in;
   logic                open_ff, open_in, peeked_ff, peeked_in;
   logic [CNT_BITS-1:0] k_ff, k_in, j_ff, j_in, cnt_ff, cnt_in;

   // response register
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [PAYLOAD_BITS-1:0] rsp_hp_ff;
   logic                    rsp_hc_ff, rsp_ht_ff, rsp_open_ff;
   logic [TAG_BITS-1:0]     rsp_hg_ff;
   logic [FIELD_CNT_BITS-1:0] rsp_cnt_ff, rsp_total_ff;

   // result of the current step
   logic                    load;
   status_type              res_status;
   logic [PAYLOAD_BITS-1:0] res_hp;
   logic                    res_hc, res_ht;
   logic [TAG_BITS-1:0]     res_hg;
   logic [CNT_BITS-1:0]     res_cnt;

   // store ports
   logic                    c_we, f_we;
   logic [PTR_BITS-1:0]     c_waddr, f_waddr, f_raddr;
   logic [FRAME_BITS-1:0]   f_wdata, f_rdata;
   logic [PAYLOAD_BITS-1:0] c_rdata;
   logic                    ram_re;

   logic [CNT_BITS-1:0] limit, frame_limit, total;
   logic                rsp_free, walk_last, match, peek_hit, walk_req;

   tcpq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(QUEUE_DEPTH)) u_control_ram (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (pay_ff),
      .re    (ram_re),
      .raddr (chead_ff),
      .rdata (c_rdata)
   );

   tcpq_ram #(.WIDTH(FRAME_BITS), .DEPTH(QUEUE_DEPTH)) u_frame_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .re    (ram_re),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   // limit in use and derived status
   always_comb begin
      if (32'(cap_ff) < QUEUE_DEPTH) begin
         limit = CNT_BITS'(cap_ff);
      end else begin
         limit = CNT_BITS'(QUEUE_DEPTH);
      end
      frame_limit = (limit != '0) ? limit - CNT_BITS'(1) : '0;
   end

   assign total     = ccount_ff + fcount_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign walk_last = ((k_ff + CNT_BITS'(1)) == fcount_ff);
   assign match     = f_rdata[FRAME_BITS-1] &&
                      (f_rdata[PAYLOAD_BITS +: TAG_BITS] == gen_ff);
   assign peek_hit  = (mode_ff == MODE_PEEK) && (total != '0);
   assign walk_req  = ((mode_ff == MODE_REMOVE) || (mode_ff == MODE_COUNT)) &&
                      (gen_ff != '0) && (fcount_ff != '0);

   always_comb begin
      stat.rsp_free  = rsp_free;
      stat.walk_last = walk_last;
      if (peek_hit) begin
         stat.kind = KIND_PEEK;
      end else if (walk_req) begin
         stat.kind = KIND_WALK;
      end else begin
         stat.kind = KIND_SINGLE;
      end
   end

   assign ram_re  = cmd.exec || cmd.walk_read;
   assign f_raddr = cmd.walk_read ? wrap_add(fhead_ff, k_ff) : fhead_ff;

   // next state of the queue and the step result
   always_comb begin
      ccount_in  = ccount_ff;
      fcount_in  = fcount_ff;
      chead_in   = chead_ff;
      fhead_in   = fhead_ff;
      open_in    = open_ff;
      peeked_in  = peeked_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      cnt_in     = cnt_ff;
      c_we       = 1'b0;
      c_waddr    = wrap_add(chead_ff, ccount_ff);
      f_we       = 1'b0;
      f_waddr    = wrap_add(fhead_ff, fcount_ff);
      f_wdata    = {tag_ff, gen_ff, pay_ff};
      load       = 1'b0;
      res_status = ST_OK;
      res_hp     = '0;
      res_hc     = 1'b0;
      res_ht     = 1'b0;
      res_hg     = '0;
      res_cnt    = '0;

      if (cmd.exec) begin
         load = (stat.kind == KIND_SINGLE);
         case (mode_ff)
            MODE_ENQUEUE: begin
               if (!open_ff) begin
                  res_status = ST_CLOSED;
               end else if ((total >= limit) || (!ctl_ff && (fcount_ff >= frame_limit))) begin
                  res_status = ST_FULL;
               end else if (ctl_ff) begin
                  c_we      = 1'b1;
                  ccount_in = ccount_ff + CNT_BITS'(1);
               end else begin
                  f_we      = 1'b1;
                  fcount_in = fcount_ff + CNT_BITS'(1);
               end
            end
            MODE_PEEK: begin
               if (ccount_ff != '0) begin
                  peeked_in = 1'b1;
               end else if (fcount_ff != '0) begin
                  peeked_in = 1'b0;
               end else begin
                  res_status = ST_EMPTY;
               end
            end
            MODE_RETIRE: begin
               if (peeked_ff && (ccount_ff != '0)) begin
                  chead_in  = wrap_add(chead_ff, CNT_BITS'(1));
                  ccount_in = ccount_ff - CNT_BITS'(1);
               end else if (!peeked_ff && (fcount_ff != '0)) begin
                  fhead_in  = wrap_add(fhead_ff, CNT_BITS'(1));
                  fcount_in = fcount_ff - CNT_BITS'(1);
               end else begin
                  res_status = ST_EMPTY;
               end
            end
            MODE_CLOSE: begin
               open_in = 1'b0;
            end
            MODE_FLUSH: begin
               res_cnt   = total;
               ccount_in = '0;
               fcount_in = '0;
            end
            MODE_REMOVE, MODE_COUNT: begin
               if (walk_req) begin
                  k_in   = '0;
                  j_in   = '0;
                  cnt_in = '0;
               end
            end
            default: begin
            end
         endcase
      end

      // head item arrives from the store picked at peek time
      if (cmd.peek_done) begin
         load = 1'b1;
         if (peeked_ff) begin
            res_hp = c_rdata;
            res_hc = 1'b1;
         end else begin
            res_hp = f_rdata[PAYLOAD_BITS-1:0];
            res_ht = f_rdata[FRAME_BITS-1];
            res_hg = f_rdata[PAYLOAD_BITS +: TAG_BITS];
         end
      end

      // count matches, compact the survivors when removing
      if (cmd.walk_step) begin
         k_in = k_ff + CNT_BITS'(1);
         if (match) begin
            cnt_in = cnt_ff + CNT_BITS'(1);
         end else if (mode_ff == MODE_REMOVE) begin
            f_we    = 1'b1;
            f_waddr = wrap_add(fhead_ff, j_ff);
            f_wdata = f_rdata;
            j_in    = j_ff + CNT_BITS'(1);
         end
         if (walk_last) begin
            load    = 1'b1;
            res_cnt = cnt_in;
            if (mode_ff == MODE_REMOVE) begin
               fcount_in = j_in;
            end
         end
      end
   end

   // request latch and result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         ctl_ff  <= req_is_control;
         tag_ff  <= req_is_tagged;
         gen_ff  <= req_generation;
         pay_ff  <= req_payload;
      end
      if (load) begin
         rsp_status_ff <= res_status;
         rsp_hp_ff     <= res_hp;
         rsp_hc_ff     <= res_hc;
         rsp_ht_ff     <= res_ht;
         rsp_hg_ff     <= res_hg;
         rsp_cnt_ff    <= FIELD_CNT_BITS'(res_cnt);
         rsp_total_ff  <= FIELD_CNT_BITS'(ccount_in + fcount_in);
         rsp_open_ff   <= open_in;
      end
   end

   // queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         ccount_ff    <= '0;
         fcount_ff    <= '0;
         chead_ff     <= '0;
         fhead_ff     <= '0;
         open_ff      <= 1'b1;
         peeked_ff    <= 1'b0;
         k_ff         <= '0;
         j_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
         ccount_ff <= ccount_in;
         fcount_ff <= fcount_in;
         chead_ff  <= chead_in;
         fhead_ff  <= fhead_in;
         open_ff   <= open_in;
         peeked_ff <= peeked_in;
         k_ff      <= k_in;
         j_ff      <= j_in;
         cnt_ff    <= cnt_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_head_payload    = rsp_hp_ff;
   assign rsp_head_is_control = rsp_hc_ff;
   assign rsp_head_is_tagged  = rsp_ht_ff;
   assign rsp_head_generation = rsp_hg_ff;
   assign rsp_item_count      = rsp_cnt_ff;
   assign rsp_total_queued    = rsp_total_ff;
   assign rsp_accepting       = rsp_open_ff;

   `TCPQ_ASSERT_IMP(a_total_bounded, clock, reset, 1'b1, (CNT_BITS+1)'(ccount_ff) + (CNT_BITS+1)'(fcount_ff) <= (CNT_BITS+1)'(QUEUE_DEPTH), "queue holds more items than storage")
   `TCPQ_ASSERT_IMP(a_load_when_free, clock, reset, load, !rsp_valid_ff || rsp_tready, "result overwrites a beat not yet taken")
   `TCPQ_ASSERT_IMP(a_compact_behind, clock, reset, cmd.walk_step, (j_ff <= k_ff) && (k_ff < fcount_ff), "compaction write passes the read position")
   `TCPQ_ASSERT_NXT(a_remove_shrinks, clock, reset, cmd.walk_step && walk_last, fcount_ff <= $past(fcount_ff), "tag walk grew the frame count")

endmodule

// ----- design/two_class_priority_queue.sv -----
`timescale 1ns / 1ps
// Enqueue, retire, close, flush, empty peek, unused modes and walks with a zero tag or no
// frames load their result beat from the execute state; a peek with an item reads the store first.
// A new request is taken only once the last one is done, and result loads wait for a free
// response register; remove/count tag run a read/check loop over the frame store.
// Reset (synchronous, active high): both FIFOs empty, intake open, capacity 16;
// store contents are not cleared.

module two_class_priority_queue
   import tcpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // mode, is_control, is_tagged
   input  logic [REQ_USER_BITS-1:0] req_tuser,
   // generation, payload
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_BITS-1:0]      csr_data,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // status, head_is_control, head_is_tagged, accepting
   output logic [RSP_USER_BITS-1:0] rsp_tuser,
   // head_payload, head_generation, item_count, total_queued, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   cmd_type    cmd;
   stat_type   stat;
   status_type rsp_status;
   logic [PAYLOAD_BITS-1:0]   rsp_head_payload;
   logic                      rsp_head_is_control, rsp_head_is_tagged, rsp_accepting;
   logic [TAG_BITS-1:0]       rsp_head_generation;
   logic [FIELD_CNT_BITS-1:0] rsp_item_count, rsp_total_queued;

   assign csr_ready = 1'b1;

   tcpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcpq_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_tuser[MODE_BITS-1:0]),
      .req_is_control      (req_tuser[MODE_BITS]),
      .req_is_tagged       (req_tuser[MODE_BITS+1]),
      .req_generation      (req_tdata[TAG_BITS-1:0]),
      .req_payload         (req_tdata[TAG_BITS +: PAYLOAD_BITS]),
      .csr_valid           (csr_valid),
      .csr_data            (csr_data),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_tready          (rsp_tready),
      .rsp_valid           (rsp_tvalid),
      .rsp_status          (rsp_status),
      .rsp_head_payload    (rsp_head_payload),
      .rsp_head_is_control (rsp_head_is_control),
      .rsp_head_is_tagged  (rsp_head_is_tagged),
      .rsp_head_generation (rsp_head_generation),
      .rsp_item_count      (rsp_item_count),
      .rsp_total_queued    (rsp_total_queued),
      .rsp_accepting       (rsp_accepting)
   );

   // pack the result beat
   assign rsp_tuser = {rsp_accepting, rsp_head_is_tagged, rsp_head_is_control,
                       logic'(rsp_status[1]), logic'(rsp_status[0])};
   assign rsp_tdata = RSP_DATA_BITS'({rsp_total_queued, rsp_item_count,
                                      rsp_head_generation, rsp_head_payload});

endmodule

// ----- test/tcpq_result_checker.sv -----
`timescale 1ns / 1ps

module tcpq_result_checker
   import tcpq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   // mode, is_control, is_tagged
   input  logic [REQ_USER_BITS-1:0] req_tuser,
   // generation, payload
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CAP_BITS-1:0]      csr_data,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // status, head_is_control, head_is_tagged, accepting
   input  logic [RSP_USER_BITS-1:0] rsp_tuser,
   // head_payload, head_generation, item_count, total_queued, zero fill
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output int                       fail_count,
   output int                       outstanding,
   output int                       results_checked
);

   localparam int REPLY_SLOTS = 16;

   typedef struct packed {
      status_type                head_status;
      logic [PAYLOAD_BITS-1:0]   head_payload;
      logic                      head_is_control;
      logic                      head_is_tagged;
      logic [TAG_BITS-1:0]       head_generation;
      logic [FIELD_CNT_BITS-1:0] item_count;
      logic [FIELD_CNT_BITS-1:0] total_queued;
      logic                      accepting;
   } queue_reply_t;

   typedef struct packed {
      logic [PAYLOAD_BITS-1:0] payload;
      logic [TAG_BITS-1:0]     generation;
      logic                    is_tag;
   } frame_slot_t;

   // Shadow copy of both FIFOs and the control state
   logic [PAYLOAD_BITS-1:0] control_words [QUEUE_DEPTH];
   frame_slot_t             frame_slots [QUEUE_DEPTH];
   int                      control_fill;
   int                      frame_fill;
   bit                      intake_open;
   bit                      peeked_control;
   logic [CAP_BITS-1:0]     capacity;

   // predicted replies in request order
   queue_reply_t reply_fifo [REPLY_SLOTS];
   int           reply_head;
   int           reply_tail;
   int           mismatches;
   int           replies_seen;

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      mismatches      = 0;
      replies_seen    = 0;
      reply_head      = 0;
      reply_tail      = 0;
   end

   // Print one line per mismatch and count it
   task automatic flag_mismatch(input string what, input logic [63:0] seen,
                                input logic [63:0] wanted);
      $display("%0t checker: %s: got 0x%0h, expected 0x%0h", $realtime, what, seen,
               wanted);
      mismatches++;
   endtask

   // Carry out one request on the shadow state and work out its reply
   task automatic apply_request(input logic [MODE_BITS-1:0] mode, input logic ctl,
                                input logic tag_bit, input logic [TAG_BITS-1:0] gen,
                                input logic [PAYLOAD_BITS-1:0] pay,
                                output queue_reply_t reply);
      int limit;
      int frame_limit;
      int kept;
      int matched;
      reply = '0;
      reply.head_status = ST_OK;
      matched = 0;
      case (mode)
         MODE_ENQUEUE: begin
            limit = (capacity < QUEUE_DEPTH) ? int'(capacity) : QUEUE_DEPTH;
            frame_limit = (limit > 0) ? limit - 1 : 0;
            if (!intake_open) begin
               reply.head_status = ST_CLOSED;
            end else if (control_fill + frame_fill >= limit ||
                         (!ctl && frame_fill >= frame_limit)) begin
               reply.head_status = ST_FULL;
            end else if (ctl) begin
               control_words[control_fill] = pay;
               control_fill++;
            end else begin
               frame_slots[frame_fill] = '{payload: pay, generation: gen, is_tag: tag_bit};
               frame_fill++;
            end
         end
         MODE_PEEK: begin
            if (control_fill > 0) begin
               peeked_control        = 1'b1;
               reply.head_payload    = control_words[0];
               reply.head_is_control = 1'b1;
            end else if (frame_fill > 0) begin
               peeked_control        = 1'b0;
               reply.head_payload    = frame_slots[0].payload;
               reply.head_is_tagged  = frame_slots[0].is_tag;
               reply.head_generation = frame_slots[0].generation;
            end else begin
               reply.head_status = ST_EMPTY;
            end
         end
         MODE_RETIRE: begin
            // pop the FIFO the last successful peek used
            if (peeked_control && control_fill > 0) begin
               for (int i = 0; i < control_fill - 1; i++)
                  control_words[i] = control_words[i + 1];
               control_fill--;
            end else if (!peeked_control && frame_fill > 0) begin
               for (int i = 0; i < frame_fill - 1; i++)
                  frame_slots[i] = frame_slots[i + 1];
               frame_fill--;
            end else begin
               reply.head_status = ST_EMPTY;
            end
         end
         MODE_CLOSE: intake_open = 1'b0;
         MODE_FLUSH: begin
            matched      = control_fill + frame_fill;
            control_fill = 0;
            frame_fill   = 0;
         end
         MODE_REMOVE: begin
            // compact the frame FIFO, keeping order of the survivors
            if (gen != '0) begin
               kept = 0;
               for (int i = 0; i < frame_fill; i++) begin
                  if (frame_slots[i].is_tag && frame_slots[i].generation == gen) begin
                     matched++;
                  end else begin
                     frame_slots[kept] = frame_slots[i];
                     kept++;
                  end
               end
               frame_fill = kept;
            end
         end
         MODE_COUNT: begin
            if (gen != '0)
               for (int i = 0; i < frame_fill; i++)
                  if (frame_slots[i].is_tag && frame_slots[i].generation == gen)
                     matched++;
         end
         default: ;
      endcase
      reply.item_count   = matched[FIELD_CNT_BITS-1:0];
      kept               = control_fill + frame_fill;
      reply.total_queued = kept[FIELD_CNT_BITS-1:0];
      reply.accepting    = intake_open;
   endtask

   always @(posedge clock) begin : watch
      queue_reply_t seen;
      queue_reply_t wanted;
      if (reset) begin
         control_fill   = 0;
         frame_fill     = 0;
         intake_open    = 1'b1;
         peeked_control = 1'b0;
         capacity       = CAP_RESET;
         reply_head     = 0;
         reply_tail     = 0;
      end else begin
         // compare the reply beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            seen.head_status     = status_type'(rsp_tuser[1:0]);
            seen.head_is_control = rsp_tuser[2];
            seen.head_is_tagged  = rsp_tuser[3];
            seen.accepting       = rsp_tuser[4];
            seen.head_payload    = rsp_tdata[PAYLOAD_BITS-1:0];
            seen.head_generation = rsp_tdata[PAYLOAD_BITS +: TAG_BITS];
            seen.item_count      = rsp_tdata[PAYLOAD_BITS + TAG_BITS +: FIELD_CNT_BITS];
            seen.total_queued    =
               rsp_tdata[PAYLOAD_BITS + TAG_BITS + FIELD_CNT_BITS +: FIELD_CNT_BITS];
            replies_seen++;
            if (reply_tail == reply_head) begin
               flag_mismatch("reply beat with no request pending", rsp_tdata, '0);
            end else begin
               wanted = reply_fifo[reply_head % REPLY_SLOTS];
               reply_head++;
               if (seen.head_status != wanted.head_status)
                  flag_mismatch("status", seen.head_status, wanted.head_status);
               if (seen.head_payload != wanted.head_payload)
                  flag_mismatch("head_payload", seen.head_payload, wanted.head_payload);
               if (seen.head_is_control != wanted.head_is_control)
                  flag_mismatch("head_is_control", seen.head_is_control,
                                wanted.head_is_control);
               if (seen.head_is_tagged != wanted.head_is_tagged)
                  flag_mismatch("head_is_tagged", seen.head_is_tagged,
                                wanted.head_is_tagged);
               if (seen.head_generation != wanted.head_generation)
                  flag_mismatch("head_generation", seen.head_generation,
                                wanted.head_generation);
               if (seen.item_count != wanted.item_count)
                  flag_mismatch("item_count", seen.item_count, wanted.item_count);
               if (seen.total_queued != wanted.total_queued)
                  flag_mismatch("total_queued", seen.total_queued, wanted.total_queued);
               if (seen.accepting != wanted.accepting)
                  flag_mismatch("accepting", seen.accepting, wanted.accepting);
            end
         end
         // track capacity writes
         if (csr_valid && csr_ready)
            capacity = csr_data;
         // predict the reply of each accepted request beat
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser[MODE_BITS-1:0], req_tuser[MODE_BITS],
                          req_tuser[MODE_BITS+1], req_tdata[TAG_BITS-1:0],
                          req_tdata[TAG_BITS +: PAYLOAD_BITS], wanted);
            if (reply_tail - reply_head >= REPLY_SLOTS)
               flag_mismatch("too many replies pending", reply_tail - reply_head, '0);
            reply_fifo[reply_tail % REPLY_SLOTS] = wanted;
            reply_tail++;
         end
      end
      fail_count      <= mismatches;
      outstanding     <= reply_tail - reply_head;
      results_checked <= replies_seen;
   end

endmodule

// ----- test/tb_two_class_priority_queue.sv -----
`timescale 1ns / 1ps

module tb_two_class_priority_queue;
   import tcpq_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 200;
   localparam int DRAIN_CYCLES   = 60;

   typedef enum {SINK_ALWAYS, SINK_COIN, SINK_SPARSE, SINK_RHYTHM} sink_style_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_USER_BITS-1:0] req_tuser = '0;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CAP_BITS-1:0]      csr_data = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int fail_count;
   int outstanding;
   int results_checked;

   // sender bookkeeping
   int requests_sent = 0;
   int mode_sent [8];
   int burst_left = 0;
   bit no_gaps = 1'b0;
   int settings_used = 1;

   // receiver bookkeeping
   bit          stall_request = 1'b0;
   bit          stall_served = 1'b0;
   int          hold_left = 0;
   int          style_left = 0;
   int          rhythm = 0;
   sink_style_t sink_style = SINK_ALWAYS;

   int quiet_cycles = 0;

   always #5 clock = ~clock;

   two_class_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   tcpq_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tuser       (rsp_tuser),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   // Offer one request beat, after a random gap (possibly none) when the burst runs out
   task automatic send_request(input logic [MODE_BITS-1:0] mode, input logic ctl,
                               input logic tag_bit, input logic [TAG_BITS-1:0] gen,
                               input logic [PAYLOAD_BITS-1:0] pay);
      int gap;
      if (burst_left == 0) begin
         if (no_gaps)
            gap = 0;
         else if ($urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 8);
         else
            gap = $urandom_range(0, 2);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= {tag_bit, ctl, mode};
      req_tdata  <= {pay, gen};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      mode_sent[mode]++;
   endtask

   // Write the capacity once every reply has come back
   task automatic set_capacity(input logic [CAP_BITS-1:0] value);
      req_tvalid <= 1'b0;
      burst_left = 0;
      // let the pending count catch up with the last accepted beat
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Small tag pool so that walks find matches
   function automatic logic [TAG_BITS-1:0] pick_generation();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return TAG_BITS'($urandom_range(1, 3));
      else if (roll < 7)
         return '0;
      else if (roll < 8)
         return '1;
      return TAG_BITS'($urandom());
   endfunction

   task automatic enqueue_random(input logic ctl);
      send_request(MODE_ENQUEUE, ctl, 1'($urandom_range(0, 1)), pick_generation(),
                   $urandom());
   endtask

   // Random traffic, mostly fill/drain and tag-walk sequences with some flushes and noise
   task automatic run_random(input int amount, input bit allow_close);
      int stop_at;
      int pick;
      int n;
      logic [MODE_BITS-1:0] mode;
      logic [TAG_BITS-1:0] tag;
      stop_at = requests_sent + amount;
      while (requests_sent < stop_at) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         n = $urandom_range(1, 6);
         if (pick < 6) begin
            // fill then drain with peek/retire pairs, leaving some unretired
            repeat (n) enqueue_random($urandom_range(0, 9) < 3);
            repeat (n) begin
               send_request(MODE_PEEK, 1'($urandom()), 1'($urandom()), pick_generation(),
                            $urandom());
               if ($urandom_range(0, 9) < 8)
                  send_request(MODE_RETIRE, 1'($urandom()), 1'($urandom()),
                               pick_generation(), $urandom());
            end
            if ($urandom_range(0, 4) == 0)
               send_request(MODE_RETIRE, 1'b0, 1'b0, '0, '0);
         end else if (pick < 8) begin
            // tagged frames, then count, remove and count again
            repeat (n % 4 + 1)
               send_request(MODE_ENQUEUE, 1'b0, 1'($urandom_range(0, 3) != 0),
                            pick_generation(), $urandom());
            tag = pick_generation();
            send_request(MODE_COUNT, 1'($urandom()), 1'($urandom()), tag, $urandom());
            send_request(MODE_REMOVE, 1'($urandom()), 1'($urandom()), tag, $urandom());
            send_request(MODE_COUNT, 1'($urandom()), 1'($urandom()), tag, $urandom());
         end else if (pick < 9) begin
            send_request(MODE_FLUSH, 1'($urandom()), 1'($urandom()), pick_generation(),
                         $urandom());
         end else begin
            // noise: any mode (close only when allowed), fields at random
            repeat (n % 4 + 1) begin
               mode = MODE_BITS'($urandom_range(0, 7));
               if (mode == MODE_CLOSE && !allow_close)
                  mode = MODE_UNUSED;
               send_request(mode, 1'($urandom()), 1'($urandom()), TAG_BITS'($urandom()),
                            $urandom());
            end
         end
      end
   endtask

   // Receiver: changing stall styles, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_request && !stall_served) begin
         stall_served = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            sink_style = sink_style_t'($urandom_range(0, 3));
            style_left = $urandom_range(20, 120);
         end
         style_left--;
         rhythm++;
         case (sink_style)
            SINK_ALWAYS: rsp_tready <= 1'b1;
            SINK_COIN:   rsp_tready <= 1'($urandom());
            SINK_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:     rsp_tready <= ((rhythm % 8) < 5);
         endcase
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d replies outstanding",
                     quiet_cycles, outstanding);
            $display("tb_two_class_priority_queue: FAIL");
            $finish;
         end
      end
   end

   initial begin
      foreach (mode_sent[i]) mode_sent[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, class priority, tag walks, unused mode, flush
      send_request(MODE_PEEK, 1'b0, 1'b0, '0, '0);
      send_request(MODE_RETIRE, 1'b0, 1'b0, '0, '0);
      send_request(MODE_ENQUEUE, 1'b1, 1'b1, '1, '1);
      send_request(MODE_ENQUEUE, 1'b0, 1'b1, '1, '0);
      send_request(MODE_ENQUEUE, 1'b0, 1'b0, 16'h1234, 32'hA5A5_A5A5);
      send_request(MODE_ENQUEUE, 1'b0, 1'b1, 16'd1, 32'h5A5A_5A5A);
      send_request(MODE_PEEK, 1'b0, 1'b0, '0, '0);
      send_request(MODE_RETIRE, 1'b0, 1'b0, '0, '0);
      send_request(MODE_PEEK, 1'b0, 1'b0, '0, '0);
      send_request(MODE_RETIRE, 1'b0, 1'b0, '0, '0);
      send_request(MODE_COUNT, 1'b0, 1'b0, 16'd1, '0);
      send_request(MODE_COUNT, 1'b0, 1'b0, '0, '0);
      send_request(MODE_REMOVE, 1'b0, 1'b0, '0, '0);
      send_request(MODE_REMOVE, 1'b0, 1'b0, 16'd1, '0);
      send_request(MODE_UNUSED, 1'b1, 1'b1, '1, '1);
      send_request(MODE_FLUSH, 1'b0, 1'b0, '0, '0);
      send_request(MODE_RETIRE, 1'b0, 1'b0, '0, '0);

      // random phases over several capacities, with one long output stall
      stall_request <= 1'b1;
      run_random(120, 1'b0);
      set_capacity(5'd0);
      run_random(30, 1'b0);
      set_capacity(5'd1);
      run_random(40, 1'b0);
      set_capacity(5'd2);
      run_random(60, 1'b0);
      set_capacity(CAP_BITS'($urandom_range(3, 15)));
      run_random(120, 1'b0);
      set_capacity(5'd16);
      run_random(150, 1'b0);
      set_capacity(5'd7);
      run_random(80, 1'b0);

      // directed: close intake, then everything after it
      send_request(MODE_ENQUEUE, 1'b0, 1'b1, 16'd7, 32'h0BAD_F00D);
      send_request(MODE_CLOSE, 1'b0, 1'b0, '0, '0);
      send_request(MODE_ENQUEUE, 1'b1, 1'b0, '0, 32'h1111_2222);
      send_request(MODE_ENQUEUE, 1'b0, 1'b1, 16'd7, 32'h3333_4444);
      send_request(MODE_PEEK, 1'b0, 1'b0, '0, '0);
      send_request(MODE_RETIRE, 1'b0, 1'b0, '0, '0);
      send_request(MODE_FLUSH, 1'b0, 1'b0, '0, '0);
      send_request(MODE_ENQUEUE, 1'b1, 1'b1, '1, '1);
      run_random(30, 1'b1);

      // drain, then let any stray beat show up
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: enqueue %0d, peek %0d, retire %0d, close %0d, flush %0d,",
               requests_sent, mode_sent[MODE_ENQUEUE], mode_sent[MODE_PEEK],
               mode_sent[MODE_RETIRE], mode_sent[MODE_CLOSE], mode_sent[MODE_FLUSH]);
      $display("remove %0d, count %0d, unused %0d; %0d replies over %0d capacity settings",
               mode_sent[MODE_REMOVE], mode_sent[MODE_COUNT], mode_sent[MODE_UNUSED],
               results_checked, settings_used);
      if (fail_count == 0 && outstanding == 0)
         $display("tb_two_class_priority_queue: PASS");
      else
         $display("tb_two_class_priority_queue: FAIL");
      $finish;
   end

endmodule
